// File: rtl/nlp_pkg.sv
package nlp_pkg;

    localparam int MAX_ELEMENTS = 16;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int DATA_W       = 16;
    localparam int POS_W        = 4;

    typedef logic signed [DATA_W-1:0] t_elem;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CNT_W-1:0]         t_cnt;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_STEP   = 2'd2
    } t_cmd;

    // One write port and one read port of the element store.
    typedef struct packed {
        logic  we;
        t_idx  waddr;
        t_elem wdata;
        t_idx  raddr;
    } t_mem_req;

    // One result item handed from the sequencer to the output register.
    typedef struct packed {
        logic             valid;
        t_elem            element;
        logic [POS_W-1:0] position;
        logic             last;
        logic             wrapped;
    } t_emit;

endpackage

// File: rtl/nlp_store.sv
module nlp_store (
    input  logic             i_clk,
    input  nlp_pkg::t_mem_req i_req,
    output nlp_pkg::t_elem   o_rdata
);
    import nlp_pkg::*;

    t_elem r_mem [MAX_ELEMENTS];
    t_elem r_rdata;

    // Synchronous write, registered read.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/nlp_seq.sv
module nlp_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  nlp_pkg::t_cmd     i_command,
    input  nlp_pkg::t_elem    i_value,
    output logic              o_ready,
    input  logic              i_out_free,
    output nlp_pkg::t_emit    o_emit,
    output nlp_pkg::t_mem_req o_mem_req,
    input  nlp_pkg::t_elem    i_rdata
);
    import nlp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ASC0,
        S_ASC,
        S_FIND,
        S_SWAP_P,
        S_SWAP_J,
        S_REV_A,
        S_REV_B,
        S_REV_C,
        S_REV_D,
        S_EMIT_RD,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    t_cnt   r_count, n_count;
    logic   r_wrapped, n_wrapped;
    t_idx   r_p, n_p;
    t_idx   r_j, n_j;
    t_idx   r_lo, n_lo;
    t_idx   r_hi, n_hi;
    t_idx   r_k, n_k;
    t_elem  r_right, n_right;
    t_elem  r_pv, n_pv;
    t_elem  r_jv, n_jv;
    t_elem  r_lov, n_lov;

    // The one shared signed comparator.
    t_elem  cmp_a, cmp_b;
    logic   lt;
    logic   is_last;
    t_idx   top_idx;

    assign lt      = cmp_a < cmp_b;
    assign top_idx = IDX_W'(r_count - 1'b1);
    assign is_last = (r_count == '0) || (CNT_W'(r_k) + 1'b1 == r_count);
    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_wrapped = r_wrapped;
        n_p       = r_p;
        n_j       = r_j;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_k       = r_k;
        n_right   = r_right;
        n_pv      = r_pv;
        n_jv      = r_jv;
        n_lov     = r_lov;
        cmp_a     = i_rdata;
        cmp_b     = r_right;

        o_mem_req       = '0;
        o_mem_req.raddr = r_k;

        o_emit          = '0;
        o_emit.element  = (r_count == '0) ? t_elem'(0) : i_rdata;
        o_emit.position = POS_W'(r_k);
        o_emit.last     = is_last;
        o_emit.wrapped  = r_wrapped;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_command)
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        CMD_APPEND: begin
                            if (r_count < CNT_W'(MAX_ELEMENTS)) begin
                                o_mem_req.we    = 1'b1;
                                o_mem_req.waddr = IDX_W'(r_count);
                                o_mem_req.wdata = i_value;
                                n_count         = r_count + 1'b1;
                            end
                        end
                        CMD_STEP: begin
                            n_k = '0;
                            if (r_count < CNT_W'(2)) begin
                                n_wrapped = 1'b1;
                                n_state   = S_EMIT_RD;
                            end else begin
                                n_wrapped       = 1'b0;
                                o_mem_req.raddr = top_idx;
                                n_p             = IDX_W'(r_count - CNT_W'(2));
                                n_state         = S_ASC0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ASC0: begin
                n_right         = i_rdata;
                o_mem_req.raddr = r_p;
                n_state         = S_ASC;
            end
            S_ASC: begin
                // i_rdata holds a[p], r_right holds a[p+1].
                if (lt) begin
                    n_pv            = i_rdata;
                    n_j             = top_idx;
                    o_mem_req.raddr = top_idx;
                    n_state         = S_FIND;
                end else begin
                    n_right = i_rdata;
                    if (r_p == '0) begin
                        n_lo      = '0;
                        n_hi      = top_idx;
                        n_wrapped = 1'b1;
                        n_state   = S_REV_A;
                    end else begin
                        n_p             = r_p - 1'b1;
                        o_mem_req.raddr = r_p - 1'b1;
                    end
                end
            end
            S_FIND: begin
                cmp_a = r_pv;
                cmp_b = i_rdata;
                if (lt) begin
                    n_jv    = i_rdata;
                    n_state = S_SWAP_P;
                end else begin
                    n_j             = r_j - 1'b1;
                    o_mem_req.raddr = r_j - 1'b1;
                end
            end
            S_SWAP_P: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_p;
                o_mem_req.wdata = r_jv;
                n_state         = S_SWAP_J;
            end
            S_SWAP_J: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_j;
                o_mem_req.wdata = r_pv;
                n_lo            = r_p + 1'b1;
                n_hi            = top_idx;
                n_state         = S_REV_A;
            end
            S_REV_A: begin
                if (r_lo < r_hi) begin
                    o_mem_req.raddr = r_lo;
                    n_state         = S_REV_B;
                end else begin
                    n_k     = '0;
                    n_state = S_EMIT_RD;
                end
            end
            S_REV_B: begin
                n_lov           = i_rdata;
                o_mem_req.raddr = r_hi;
                n_state         = S_REV_C;
            end
            S_REV_C: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_lo;
                o_mem_req.wdata = i_rdata;
                n_state         = S_REV_D;
            end
            S_REV_D: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_hi;
                o_mem_req.wdata = r_lov;
                n_lo            = r_lo + 1'b1;
                n_hi            = r_hi - 1'b1;
                n_state         = S_REV_A;
            end
            S_EMIT_RD: begin
                o_mem_req.raddr = r_k;
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_emit.valid = 1'b1;
                    if (is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k             = r_k + 1'b1;
                        o_mem_req.raddr = r_k + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_wrapped <= n_wrapped;
        r_p       <= n_p;
        r_j       <= n_j;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_k       <= n_k;
        r_right   <= n_right;
        r_pv      <= n_pv;
        r_jv      <= n_jv;
        r_lov     <= n_lov;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

endmodule

// File: rtl/next_lexicographic_permutation.sv
// Next lexicographic permutation of a small multiset of signed 16-bit values.
// Each input item carries a command: clear empties the array, append adds the
// value at the end (dropped when the array already holds MAX_ELEMENTS values),
// and step moves the array to its next permutation in ascending lexicographic
// order and then returns the whole array, one result item per element, with
// last set on the final one. When no next permutation exists, the array is
// reversed back to ascending order and every result of that step has wrapped
// set; a step on zero or one element changes nothing and also reports
// wrapped, an empty array giving a single result with element zero.
// Clear and append leave the block ready for the next item. A step keeps
// the block busy with its work on the array and then with its output,
// and a stalled output lengthens the step; the block is not ready during
// all that. The length of a step is set by the element store, which has
// one read port and one write port, and by the single signed comparator
// that both scans share: the search for the rightmost ascent and for the
// swap partner each visit one element per cycle, a swap takes two writes,
// and every pair of the reversed suffix takes two reads and two writes.
// Results leave through an output register, so the block can take the
// next item while the last result of a step is still waiting to be taken.
module next_lexicographic_permutation (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  nlp_pkg::t_cmd    i_command,
    input  nlp_pkg::t_elem   i_value,
    output logic             o_valid,
    input  logic             i_ready,
    output nlp_pkg::t_elem   o_element,
    output logic [3:0]       o_position,
    output logic             o_last,
    output logic             o_wrapped
);
    import nlp_pkg::*;

    t_mem_req mem_req;
    t_elem    rdata;
    t_emit    emit;
    logic     out_free;

    logic             r_out_valid;
    t_elem            r_element;
    logic [POS_W-1:0] r_position;
    logic             r_last;
    logic             r_wrapped;

    // The output register can take a new item when it is empty or when its
    // current item is being taken in this cycle.
    assign out_free = !r_out_valid || i_ready;

    nlp_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    nlp_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_command  (i_command),
        .i_value    (i_value),
        .o_ready    (o_ready),
        .i_out_free (out_free),
        .o_emit     (emit),
        .o_mem_req  (mem_req),
        .i_rdata    (rdata)
    );

    // Output register: the payload loads only with a new result, so it holds
    // steady while the consumer stalls.
    always_ff @(posedge i_clk) begin
        if (emit.valid) begin
            r_element  <= emit.element;
            r_position <= emit.position;
            r_last     <= emit.last;
            r_wrapped  <= emit.wrapped;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit.valid;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_element  = r_element;
    assign o_position = r_position;
    assign o_last     = r_last;
    assign o_wrapped  = r_wrapped;

endmodule

// File: bench/next_lexicographic_permutation_test.sv
module next_lexicographic_permutation_test;

    import nlp_pkg::*;

    // The command encoding that the block has no use for. It must be ignored.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // The random part stops once this many meaningful commands are queued.
    localparam int RANDOM_ITEMS   = 360;
    // Idling stops when fewer than this many items are still waiting to be sent.
    localparam int QUIET_TAIL     = 40;
    // A step on sixteen elements keeps the block busy for less than this when
    // nothing stalls, so this is enough for any result still in flight.
    localparam int DRAIN_CYCLES   = 120;
    // The slowest gap between two handshakes is a full-size step followed
    // by the longest stall on the output, which is far below this.
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [1:0] cmd;
        t_elem      value;
    } t_command_item;

    typedef struct {
        t_elem      element;
        logic [3:0] position;
        logic       last;
        logic       wrapped;
    } t_emitted_elem;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  o_ready;
    t_cmd  i_command = CMD_CLEAR;
    t_elem i_value   = '0;
    logic  o_valid;
    logic  i_ready   = 1'b0;
    t_elem o_element;
    logic [3:0] o_position;
    logic  o_last;
    logic  o_wrapped;

    next_lexicographic_permutation dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_command  (i_command),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_element  (o_element),
        .o_position (o_position),
        .o_last     (o_last),
        .o_wrapped  (o_wrapped)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Items waiting to be sent, and the results that the accepted steps
    // must still produce, oldest first.
    t_command_item pending_items[$];
    t_emitted_elem expected_results[$];

    // Our own copy of the array. Only entries below perm_count are ever read.
    t_elem perm_store[MAX_ELEMENTS];
    int    perm_count = 0;

    int mismatch_count = 0;
    int queued_count   = 0;
    int total_items    = 0;
    int accepted_count = 0;
    int send_gap       = 0;
    int recv_gap       = 0;
    int idle_cycles    = 0;

    // Idling is switched off for the last stretch of the run.
    function automatic bit quiet();
        return (pending_items.size() < QUIET_TAIL);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic swap_elems(input int a, input int b);
        t_elem t;
        t = perm_store[a];
        perm_store[a] = perm_store[b];
        perm_store[b] = t;
    endtask

    // Applies one accepted command to our copy of the array and, for a
    // step, queues the whole array as the results that the block owes us.
    task automatic apply_command(input t_command_item item);
        int  p;
        int  j;
        int  lo;
        int  hi;
        int  k;
        bit  wrapped;
        t_emitted_elem r;
        case (item.cmd)
            CMD_CLEAR: begin
                perm_count = 0;
            end
            CMD_APPEND: begin
                // A full array silently drops the value.
                if (perm_count < MAX_ELEMENTS) begin
                    perm_store[perm_count] = item.value;
                    perm_count++;
                end
            end
            CMD_STEP: begin
                wrapped = 1'b1;
                if (perm_count >= 2) begin
                    // Find the rightmost ascent; elements compare as signed.
                    p = -1;
                    for (k = perm_count - 2; k >= 0; k--) begin
                        if (perm_store[k] < perm_store[k + 1]) begin
                            p = k;
                            break;
                        end
                    end
                    if (p >= 0) begin
                        // Swap with the rightmost larger element, then
                        // reverse everything after the ascent.
                        j = perm_count - 1;
                        while (!(perm_store[p] < perm_store[j]))
                            j--;
                        swap_elems(p, j);
                        lo = p + 1;
                        wrapped = 1'b0;
                    end else begin
                        // Last permutation: back to ascending order.
                        lo = 0;
                    end
                    hi = perm_count - 1;
                    while (lo < hi) begin
                        swap_elems(lo, hi);
                        lo++;
                        hi--;
                    end
                end
                if (perm_count == 0) begin
                    r.element  = '0;
                    r.position = '0;
                    r.last     = 1'b1;
                    r.wrapped  = 1'b1;
                    expected_results.push_back(r);
                end else begin
                    for (k = 0; k < perm_count; k++) begin
                        r.element  = perm_store[k];
                        r.position = k[3:0];
                        r.last     = (k == perm_count - 1);
                        r.wrapped  = wrapped;
                        expected_results.push_back(r);
                    end
                end
            end
            default: begin
                // The unused command changes nothing.
            end
        endcase
    endtask

    task automatic push_item(input logic [1:0] cmd, input t_elem value);
        t_command_item item;
        item.cmd   = cmd;
        item.value = value;
        pending_items.push_back(item);
        if (cmd != CMD_UNUSED)
            queued_count++;
    endtask

    // A narrow range gives many repeated values, which is where the
    // multiset handling of the step differs from plain permutations.
    function automatic t_elem rand_value(input bit narrow);
        if (narrow)
            return t_elem'(int'($urandom_range(0, 4)) - 2);
        return t_elem'($urandom());
    endfunction

    // Driver: sends the queued items, with random bursts of idle cycles.
    // Valid is assigned at most once per edge, so back-to-back items keep
    // it high without a glitch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                apply_command('{cmd: i_command, value: i_value});
                accepted_count++;
            end
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_items.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (!quiet() && $urandom_range(0, 7) == 0) begin
                    // This cycle counts as the first of the burst.
                    send_gap = $urandom_range(1, 11) - 1;
                    i_valid <= 1'b0;
                end else begin
                    i_valid   <= 1'b1;
                    i_command <= t_cmd'(pending_items[0].cmd);
                    i_value   <= pending_items[0].value;
                    void'(pending_items.pop_front());
                end
            end
        end
    end

    // Monitor: checks every accepted result against the oldest expectation
    // and stalls the output at random.
    always @(posedge i_clk) begin
        t_emitted_elem exp_r;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result element %0d position %0d",
                                              o_element, o_position));
                end else begin
                    exp_r = expected_results.pop_front();
                    if (o_element !== exp_r.element)
                        report_mismatch($sformatf("element %0d, expected %0d at position %0d",
                                                  o_element, exp_r.element, exp_r.position));
                    if (o_position !== exp_r.position)
                        report_mismatch($sformatf("position %0d, expected %0d",
                                                  o_position, exp_r.position));
                    if (o_last !== exp_r.last)
                        report_mismatch($sformatf("last %b, expected %b at position %0d",
                                                  o_last, exp_r.last, exp_r.position));
                    if (o_wrapped !== exp_r.wrapped)
                        report_mismatch($sformatf("wrapped %b, expected %b at position %0d",
                                                  o_wrapped, exp_r.wrapped, exp_r.position));
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                i_ready <= 1'b0;
            end else if (!quiet() && $urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(1, 11) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog: a hang shows up as a long run of cycles with no handshake
    // on either side.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int n;
        int steps;
        int k;
        int s;
        bit narrow;

        // Directed part. The array starts empty, so the first step must
        // return a single zero element flagged as wrapped.
        push_item(CMD_STEP, 16'sh0000);
        // The unused command with every value bit set must be ignored.
        push_item(CMD_UNUSED, 16'shFFFF);
        // A single element never moves and always reports wrapped.
        push_item(CMD_APPEND, 16'sh7FFF);
        push_item(CMD_STEP, 16'sh0000);
        // [max, min] is the last permutation: the first step wraps back to
        // ascending order, the second one swaps the pair.
        push_item(CMD_APPEND, 16'sh8000);
        push_item(CMD_STEP, 16'sh0000);
        push_item(CMD_STEP, 16'sh0000);
        // Fill the array past its capacity with repeated and extreme values,
        // so the seventeenth append is dropped, then step the full array.
        push_item(CMD_CLEAR, 16'sh0000);
        for (k = 0; k < MAX_ELEMENTS + 1; k++) begin
            case (k % 4)
                0: push_item(CMD_APPEND, 16'sh8000);
                1: push_item(CMD_APPEND, 16'sh7FFF);
                2: push_item(CMD_APPEND, 16'shFFFF);
                default: push_item(CMD_APPEND, 16'sh0000);
            endcase
        end
        push_item(CMD_STEP, 16'sh0000);

        // Random part: mostly clear, a few appends and a run of steps, so
        // that small arrays go all the way round and wrap. Now and then a
        // clear is skipped, an array is filled past capacity, or a stray
        // command breaks into the run of steps.
        while (queued_count < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) != 0)
                push_item(CMD_CLEAR, rand_value(1'b0));
            if ($urandom_range(0, 7) == 0)
                n = $urandom_range(7, MAX_ELEMENTS + 2);
            else
                n = $urandom_range(0, 6);
            narrow = $urandom_range(0, 1);
            for (k = 0; k < n; k++)
                push_item(CMD_APPEND, rand_value(narrow));
            if (n > 6)
                steps = $urandom_range(1, 3);
            else
                steps = $urandom_range(1, 30);
            for (s = 0; s < steps; s++) begin
                if ($urandom_range(0, 19) == 0) begin
                    case ($urandom_range(0, 2))
                        0: push_item(CMD_UNUSED, rand_value(1'b0));
                        1: push_item(CMD_APPEND, rand_value(narrow));
                        default: push_item(CMD_CLEAR, rand_value(1'b0));
                    endcase
                end
                push_item(CMD_STEP, rand_value(1'b0));
            end
        end
        total_items = pending_items.size();

        // Synchronous reset, released at a rising edge.
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count < total_items)
            @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        // Give any stray result time to show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: next_lexicographic_permutation.f
rtl/nlp_pkg.sv
rtl/nlp_store.sv
rtl/nlp_seq.sv
rtl/next_lexicographic_permutation.sv
bench/next_lexicographic_permutation_test.sv
